// File: rtl/wfc_pkg.sv
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared constants for the word frequency counter.
// ----------------------------------------------------------------------------
package wfc_pkg;

   localparam int MAX_WORDS    = 64;
   localparam int MAX_WORD_LEN = 32;
   localparam int COUNT_BITS   = 10;

   localparam int IDX_W   = $clog2(MAX_WORDS);
   localparam int LEN_W   = $clog2(MAX_WORD_LEN);
   localparam int CHR_AW  = $clog2(MAX_WORDS * MAX_WORD_LEN);

   localparam logic [7:0] SEPARATOR = 8'd32;

   localparam logic [1:0] STATUS_EXISTING = 2'd0;
   localparam logic [1:0] STATUS_NEW      = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

endpackage

// File: rtl/wfc_ram.sv
// ----------------------------------------------------------------------------
// wfc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module wfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/word_frequency_counter.sv
// ----------------------------------------------------------------------------
// word_frequency_counter
// Counts distinct space-separated words of a byte stream.
// ----------------------------------------------------------------------------
// Bytes that do not end a word are taken while the block is idle. When a word
// ends, the table is searched one entry at a time: the stored length of each
// entry is checked first, and its bytes are compared one by one only when the
// length is equal. A new word is then copied into the table at one byte per
// cycle. The search and copy are bounded by the single read port of the
// character memory. A finished result waits in an output register while
// further bytes of the next word are taken.
module word_frequency_counter
   import wfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_text_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_word_index,
   output logic [COUNT_BITS-1:0] rsp_word_count,
   output logic [1:0]            rsp_status,
   output logic                  rsp_was_truncated,
   output logic                  rsp_end_of_text
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_LCHK   = 3'd2;
   localparam logic [2:0] ST_CCHK   = 3'd3;
   localparam logic [2:0] ST_HIT    = 3'd4;
   localparam logic [2:0] ST_COPY   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam logic [LEN_W:0]      LEN_MAX = (LEN_W+1)'(MAX_WORD_LEN);
   localparam logic [IDX_W:0]      ENT_MAX = (IDX_W+1)'(MAX_WORDS);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [2:0]            state_ff, state_in;
   logic [LEN_W:0]        len_ff, len_in;
   logic                  trunc_ff, trunc_in;
   logic                  end_ff, end_in;
   logic [IDX_W:0]        ent_ff, ent_in;
   logic [IDX_W:0]        used_ff, used_in;
   logic [LEN_W:0]        k_ff, k_in;
   logic [COUNT_BITS-1:0] pcnt_ff, pcnt_in;
   logic [1:0]            pstat_ff, pstat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_trunc_ff, rsp_trunc_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic                  buf_we;
   logic [7:0]            buf_rd;
   logic                  chr_we;
   logic [7:0]            chr_rd;
   logic [CHR_AW-1:0]     chr_wr_addr, chr_rd_addr;
   logic                  lr_we;
   logic [LEN_W:0]        lr_rd;
   logic                  cr_we;
   logic [COUNT_BITS-1:0] cr_wdata, cr_rd;

   assign chr_wr_addr = CHR_AW'(ent_ff[IDX_W-1:0]) * CHR_AW'(MAX_WORD_LEN)
                        + CHR_AW'(k_ff[LEN_W-1:0]);
   assign chr_rd_addr = CHR_AW'(ent_ff[IDX_W-1:0]) * CHR_AW'(MAX_WORD_LEN)
                        + CHR_AW'(k_in[LEN_W-1:0]);

   wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(len_ff[LEN_W-1:0]),
      .wr_data(req_char_code), .rd_addr(k_in[LEN_W-1:0]), .rd_data(buf_rd));

   wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORDS * MAX_WORD_LEN)) u_chars (
      .clock(clock), .wr_en(chr_we), .wr_addr(chr_wr_addr),
      .wr_data(buf_rd), .rd_addr(chr_rd_addr), .rd_data(chr_rd));

   wfc_ram #(.WIDTH(LEN_W+1), .DEPTH(MAX_WORDS)) u_lengths (
      .clock(clock), .wr_en(lr_we), .wr_addr(ent_ff[IDX_W-1:0]),
      .wr_data(len_ff), .rd_addr(ent_ff[IDX_W-1:0]), .rd_data(lr_rd));

   wfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_WORDS)) u_counts (
      .clock(clock), .wr_en(cr_we), .wr_addr(ent_ff[IDX_W-1:0]),
      .wr_data(cr_wdata), .rd_addr(ent_ff[IDX_W-1:0]), .rd_data(cr_rd));

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      trunc_in      = trunc_ff;
      end_in        = end_ff;
      ent_in        = ent_ff;
      used_in       = used_ff;
      k_in          = k_ff;
      pcnt_in       = pcnt_ff;
      pstat_in      = pstat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      rsp_end_in    = rsp_end_ff;
      buf_we        = 1'b0;
      chr_we        = 1'b0;
      lr_we         = 1'b0;
      cr_we         = 1'b0;
      cr_wdata      = cr_rd;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_char_code == SEPARATOR) begin
                  if (len_ff != '0) begin
                     end_in   = req_text_end;
                     ent_in   = '0;
                     k_in     = '0;
                     state_in = ST_SEARCH;
                  end
               end else begin
                  if (len_ff < LEN_MAX) begin
                     buf_we = 1'b1;
                     len_in = len_ff + 1'b1;
                  end else begin
                     trunc_in = 1'b1;
                  end
                  if (req_text_end) begin
                     end_in   = 1'b1;
                     ent_in   = '0;
                     k_in     = '0;
                     state_in = ST_SEARCH;
                  end
               end
            end
         end
         ST_SEARCH: begin
            k_in = '0;
            if (ent_ff == used_ff) begin
               if (used_ff == ENT_MAX) begin
                  pstat_in = STATUS_FULL;
                  pcnt_in  = '0;
                  ent_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_COPY;
               end
            end else begin
               state_in = ST_LCHK;
            end
         end
         ST_LCHK: begin
            k_in = '0;
            if (lr_rd == len_ff) begin
               state_in = ST_CCHK;
            end else begin
               ent_in   = ent_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_CCHK: begin
            if (chr_rd != buf_rd) begin
               ent_in   = ent_ff + 1'b1;
               state_in = ST_SEARCH;
            end else if (k_ff + 1'b1 == len_ff) begin
               state_in = ST_HIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_HIT: begin
            cr_we    = 1'b1;
            cr_wdata = (cr_rd == CNT_MAX) ? cr_rd : cr_rd + 1'b1;
            pcnt_in  = cr_wdata;
            pstat_in = STATUS_EXISTING;
            state_in = ST_DONE;
         end
         ST_COPY: begin
            chr_we = 1'b1;
            if (k_ff + 1'b1 == len_ff) begin
               lr_we    = 1'b1;
               cr_we    = 1'b1;
               cr_wdata = COUNT_BITS'(1);
               used_in  = used_ff + 1'b1;
               pcnt_in  = COUNT_BITS'(1);
               pstat_in = STATUS_NEW;
               state_in = ST_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = ent_ff[IDX_W-1:0];
               rsp_count_in  = pcnt_ff;
               rsp_status_in = pstat_ff;
               rsp_trunc_in  = trunc_ff;
               rsp_end_in    = end_ff;
               len_in        = '0;
               trunc_in      = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         trunc_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         trunc_ff     <= trunc_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff        <= end_in;
      ent_ff        <= ent_in;
      k_ff          <= k_in;
      pcnt_ff       <= pcnt_in;
      pstat_ff      <= pstat_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_trunc_ff  <= rsp_trunc_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word_index    = rsp_index_ff;
   assign rsp_word_count    = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_was_truncated = rsp_trunc_ff;
   assign rsp_end_of_text   = rsp_end_ff;

endmodule

// File: rtl/wfc_checker.sv
// ----------------------------------------------------------------------------
// wfc_checker
// Port-level checks of the word frequency counter.
// ----------------------------------------------------------------------------
module wfc_checker
   import wfc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [IDX_W-1:0]      rsp_word_index,
   input logic [COUNT_BITS-1:0] rsp_word_count,
   input logic [1:0]            rsp_status
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_count)
         && $stable(rsp_word_index) && $stable(rsp_status))
      else $error("Result transaction changed while stalled.");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_EXISTING || rsp_status == STATUS_NEW
         || rsp_status == STATUS_FULL))
      else $error("Unknown status code.");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_word_index == '0
         && rsp_word_count == '0)
      else $error("Dropped word carries an index or count.");

   a_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NEW |-> rsp_word_count == COUNT_BITS'(1))
      else $error("New entry count is not one.");

   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EXISTING |-> rsp_word_count > COUNT_BITS'(1))
      else $error("Repeated word count below two.");

endmodule

bind word_frequency_counter wfc_checker u_wfc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_word_index(rsp_word_index), .rsp_word_count(rsp_word_count),
   .rsp_status(rsp_status));

// File: bench/wfc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wfc_scoreboard
// Watches both channels of the word frequency counter, keeps its own word
// table, predicts the result of every finished word and compares each result
// transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module wfc_scoreboard
   import wfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_text_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [IDX_W-1:0]      rsp_word_index,
   input  logic [COUNT_BITS-1:0] rsp_word_count,
   input  logic [1:0]            rsp_status,
   input  logic                  rsp_was_truncated,
   input  logic                  rsp_end_of_text,
   output int                    failures,
   output int                    words_pending,
   output int                    words_checked,
   output int                    words_dropped
);

   typedef struct packed {
      logic [IDX_W-1:0]      word_index;
      logic [COUNT_BITS-1:0] word_count;
      logic [1:0]            status;
      logic                  was_truncated;
      logic                  end_of_text;
   } word_result_type;

   localparam int COUNT_TOP = (1 << COUNT_BITS) - 1;

   word_result_type    expected_words[$];
   logic [7:0]         pending_chars[MAX_WORD_LEN];
   int                 pending_len;
   logic               pending_cut;
   logic [7:0]         entry_chars[MAX_WORDS][MAX_WORD_LEN];
   int                 entry_len[MAX_WORDS];
   int                 entry_count[MAX_WORDS];
   int                 entries_filled;

   initial begin
      failures = 0;
      words_checked = 0;
      words_dropped = 0;
      pending_len = 0;
      pending_cut = 1'b0;
      entries_filled = 0;
   end

   assign words_pending = expected_words.size();

   function automatic word_result_type count_word(input logic last_flag);
      word_result_type r;
      int              hit;
      hit = -1;
      r = '0;
      r.status = STATUS_FULL;
      for (int e = 0; e < entries_filled && hit < 0; e++) begin
         if (entry_len[e] == pending_len) begin
            hit = e;
            for (int k = 0; k < pending_len; k++)
               if (entry_chars[e][k] !== pending_chars[k]) hit = -1;
         end
      end
      if (hit >= 0) begin
         if (entry_count[hit] < COUNT_TOP) entry_count[hit]++;
         r.word_index = hit[IDX_W-1:0];
         r.word_count = entry_count[hit][COUNT_BITS-1:0];
         r.status = STATUS_EXISTING;
      end else if (entries_filled < MAX_WORDS) begin
         for (int k = 0; k < pending_len; k++)
            entry_chars[entries_filled][k] = pending_chars[k];
         entry_len[entries_filled] = pending_len;
         entry_count[entries_filled] = 1;
         r.word_index = entries_filled[IDX_W-1:0];
         r.word_count = COUNT_BITS'(1);
         r.status = STATUS_NEW;
         entries_filled++;
      end
      r.was_truncated = pending_cut;
      r.end_of_text = last_flag;
      pending_len = 0;
      pending_cut = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      word_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               failures++;
               $display("%0t: result transaction with no word pending: idx %0d cnt %0d st %0d",
                        $time, rsp_word_index, rsp_word_count, rsp_status);
            end else begin
               want = expected_words.pop_front();
               if (want.status == STATUS_FULL) words_dropped++;
               if (rsp_word_index !== want.word_index) begin
                  failures++;
                  $display("%0t: word_index expected %0d actual %0d",
                           $time, want.word_index, rsp_word_index);
               end
               if (rsp_word_count !== want.word_count) begin
                  failures++;
                  $display("%0t: word_count expected %0d actual %0d",
                           $time, want.word_count, rsp_word_count);
               end
               if (rsp_status !== want.status) begin
                  failures++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_was_truncated !== want.was_truncated) begin
                  failures++;
                  $display("%0t: was_truncated expected %0d actual %0d",
                           $time, want.was_truncated, rsp_was_truncated);
               end
               if (rsp_end_of_text !== want.end_of_text) begin
                  failures++;
                  $display("%0t: end_of_text expected %0d actual %0d",
                           $time, want.end_of_text, rsp_end_of_text);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_char_code == SEPARATOR) begin
               if (pending_len > 0) expected_words.push_back(count_word(req_text_end));
            end else begin
               if (pending_len < MAX_WORD_LEN) begin
                  pending_chars[pending_len] = req_char_code;
                  pending_len++;
               end else begin
                  pending_cut = 1'b1;
               end
               if (req_text_end) expected_words.push_back(count_word(1'b1));
            end
         end
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives text into the word frequency counter: a directed opening with the
// edge cases, a long run of one word that drives its count into saturation,
// then random sentences drawn from a small vocabulary that fills the table,
// mixed with noise bytes, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
   import wfc_pkg::*;

   localparam int TOTAL_ITEMS  = 1800;
   localparam int VOCAB_SIZE   = 96;
   localparam int VOCAB_MAXLEN = 40;
   localparam int CYCLE_LIMIT  = 20000000;
   localparam int DRAIN_CYCLES = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_char_code = 8'd0;
   logic                  req_text_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [IDX_W-1:0]      rsp_word_index;
   logic [COUNT_BITS-1:0] rsp_word_count;
   logic [1:0]            rsp_status;
   logic                  rsp_was_truncated;
   logic                  rsp_end_of_text;

   int failures;
   int words_pending;
   int words_checked;
   int words_dropped;
   int cycles = 0;
   int items_sent = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   logic [7:0] vocab[VOCAB_SIZE][VOCAB_MAXLEN];
   int         vocab_len[VOCAB_SIZE];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   word_frequency_counter dut (.*);

   wfc_scoreboard checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] code, input logic last_flag);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_text_end <= last_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [7:0] word_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == SEPARATOR);
      return c;
   endfunction

   task automatic send_vocab_word(input int w);
      logic ends_text;
      ends_text = ($urandom_range(9) == 0);
      for (int k = 0; k < vocab_len[w]; k++)
         send_char(vocab[w][k], ends_text && (k == vocab_len[w] - 1));
      if (!ends_text) begin
         send_char(SEPARATOR, $urandom_range(9) == 0);
         if ($urandom_range(7) == 0) send_char(SEPARATOR, $urandom_range(1) == 1);
      end
   endtask

   initial begin
      int random_start;
      for (int i = 0; i < VOCAB_SIZE; i++) begin
         vocab_len[i] = (i % 20 == 19) ? $urandom_range(33, VOCAB_MAXLEN)
                                       : $urandom_range(1, 4);
         for (int k = 0; k < VOCAB_MAXLEN; k++) vocab[i][k] = word_char();
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_char(8'h61, 1'b0);
      send_char(SEPARATOR, 1'b0);
      send_char(8'h61, 1'b0);
      send_char(SEPARATOR, 1'b0);
      send_char(SEPARATOR, 1'b1);
      send_char(8'h00, 1'b1);
      send_char(SEPARATOR, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h7F, 1'b0);
      send_char(SEPARATOR, 1'b1);
      for (int k = 0; k < 34; k++) send_char(8'h41 + 8'(k % 20), 1'b0);
      send_char(SEPARATOR, 1'b0);
      for (int k = 0; k < 37; k++) send_char(8'h41 + 8'(k % 20), k == 36);

      // Repeat one short word until its count saturates.
      for (int n = 0; n < 1030; n++) begin
         send_char(8'h61, 1'b1);
      end

      random_start = items_sent;
      while (items_sent < TOTAL_ITEMS) begin
         case (((items_sent - random_start) / 120) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            3: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         if ($urandom_range(99) < 8)
            send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
         else if ($urandom_range(99) < 70)
            send_vocab_word($urandom_range(39));
         else
            send_vocab_word($urandom_range(VOCAB_SIZE - 1));
      end
      send_char(8'h62, 1'b1);
      req_valid <= 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d text bytes, checked %0d words (%0d dropped on a full table)",
               items_sent, words_checked, words_dropped);
      if (failures == 0 && words_pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/wfc_pkg.sv
rtl/wfc_ram.sv
rtl/word_frequency_counter.sv
rtl/wfc_checker.sv
bench/wfc_checker.sv
bench/testbench.sv
